// ===== rtl/lir_pkg.sv =====
// Shared constants and control types for the linear interpolation resampler.
// No dependencies; every other file refers to it by scoped names.
package lir_pkg;

	localparam int STEP_BITS = 20;
	localparam logic [STEP_BITS-1:0] STEP_RESET = 20'd65536;
	localparam int MAX_OUTS = 64;
	localparam int CNT_BITS = $clog2(MAX_OUTS + 1);
	localparam int PEND_BITS = 5;
	localparam logic [PEND_BITS-1:0] PEND_MAX = 5'd31;

	typedef struct packed {
		logic prime;
		logic skip;
		logic start;
		logic step;
		logic emit;
		logic retire;
	} lir_cmd_t;

	typedef struct packed {
		logic have_prev;
		logic pend_zero;
		logic last_out;
	} lir_stat_t;

endpackage

// ===== rtl/lir_if.sv =====
// Channel interfaces of the resampler: input samples, output samples and
// the step configuration write. Depends on lir_pkg for the step width.
interface lir_in_if #(parameter int SAMPLE_BITS = 16);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] sample_in;
	modport source (output valid, output sample_in, input ready);
	modport sink (input valid, input sample_in, output ready);
endinterface

interface lir_out_if #(parameter int SAMPLE_BITS = 16);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] sample_out;
	logic                          last;
	modport source (output valid, output sample_out, output last, input ready);
	modport sink (input valid, input sample_out, input last, output ready);
endinterface

interface lir_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [lir_pkg::STEP_BITS-1:0]   phase_step;
	modport source (output valid, output phase_step, input ready);
	modport sink (input valid, input phase_step, output ready);
endinterface

// ===== rtl/lir_datapath.sv =====
// Datapath of the resampler: sample store, phase accumulator, multiplier
// and output register. Depends on lir_pkg; driven by lir_ctrl commands.
module lir_datapath #(
	parameter int SAMPLE_BITS = 16,
	parameter int FRAC_BITS = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  lir_pkg::lir_cmd_t               cmd,
	output lir_pkg::lir_stat_t              stat,
	input  logic signed [SAMPLE_BITS-1:0]   sample_in,
	input  logic                            step_we,
	input  logic [lir_pkg::STEP_BITS-1:0]   step_data,
	output logic signed [SAMPLE_BITS-1:0]   sample_out,
	output logic                            last
);
	localparam int PW = SAMPLE_BITS + FRAC_BITS + 2;
	localparam int SUM_BITS = lir_pkg::STEP_BITS + 1;
	localparam int CARRY_BITS = SUM_BITS - FRAC_BITS;
	localparam int QW = PW - FRAC_BITS;

	logic signed [SAMPLE_BITS-1:0]       cur_q;
	logic signed [SAMPLE_BITS-1:0]       prev_q;
	logic                                have_prev_q;
	logic [FRAC_BITS-1:0]                phase_q;
	logic [lir_pkg::PEND_BITS-1:0]       pend_q;
	logic [lir_pkg::CNT_BITS-1:0]        cnt_q;
	logic [lir_pkg::STEP_BITS-1:0]       step_q;
	logic signed [PW-1:0]                prod_s1;
	logic signed [SAMPLE_BITS-1:0]       out_sample_q;
	logic                                out_last_q;

	logic signed [SAMPLE_BITS:0]         diff;
	logic signed [FRAC_BITS:0]           frac_s;
	logic [SUM_BITS-1:0]                 sum;
	logic [CARRY_BITS-1:0]               carry;
	logic [lir_pkg::PEND_BITS-1:0]       carry_sat;
	logic signed [PW-1:0]                prev_sh;
	logic signed [PW-1:0]                num;
	logic [QW-1:0]                       quo;
	logic                                rnd;
	logic [QW-1:0]                       quo_adj;

	assign diff = {cur_q[SAMPLE_BITS-1], cur_q} - {prev_q[SAMPLE_BITS-1], prev_q};
	assign frac_s = {1'b0, phase_q};
	assign sum = SUM_BITS'(phase_q) + SUM_BITS'(step_q);
	assign carry = sum[SUM_BITS-1:FRAC_BITS];
	assign carry_sat = (carry > CARRY_BITS'(lir_pkg::PEND_MAX)) ? lir_pkg::PEND_MAX :
		carry[lir_pkg::PEND_BITS-1:0];

	// Truncation toward zero of the fixed-point interpolation.
	assign prev_sh = {{2{prev_q[SAMPLE_BITS-1]}}, prev_q, {FRAC_BITS{1'b0}}};
	assign num = prev_sh + prod_s1;
	assign quo = num[PW-1:FRAC_BITS];
	assign rnd = num[PW-1] && (|num[FRAC_BITS-1:0]);
	assign quo_adj = quo + QW'(rnd);

	assign stat.have_prev = have_prev_q;
	assign stat.pend_zero = (pend_q == '0);
	assign stat.last_out = (pend_q != '0) ||
		(cnt_q == lir_pkg::CNT_BITS'(lir_pkg::MAX_OUTS));

	assign sample_out = out_sample_q;
	assign last = out_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_prev_q <= 1'b0;
			phase_q <= '0;
			pend_q <= '0;
			cnt_q <= '0;
			step_q <= lir_pkg::STEP_RESET;
		end else begin
			if (step_we) begin
				step_q <= step_data;
			end
			if (cmd.prime) begin
				have_prev_q <= 1'b1;
			end
			if (cmd.skip) begin
				pend_q <= pend_q - 1'b1;
			end
			if (cmd.start) begin
				cnt_q <= '0;
			end
			if (cmd.step) begin
				phase_q <= sum[FRAC_BITS-1:0];
				pend_q <= carry_sat;
				cnt_q <= cnt_q + 1'b1;
			end
			if (cmd.retire && (pend_q != '0)) begin
				pend_q <= pend_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.prime || cmd.skip) begin
			prev_q <= sample_in;
		end
		if (cmd.start) begin
			cur_q <= sample_in;
		end
		if (cmd.step) begin
			prod_s1 <= diff * frac_s;
		end
		if (cmd.emit) begin
			out_sample_q <= quo_adj[SAMPLE_BITS-1:0];
			out_last_q <= stat.last_out;
		end
		if (cmd.retire) begin
			prev_q <= cur_q;
		end
	end

endmodule

// ===== rtl/lir_ctrl.sv =====
// Controller of the resampler: sequences one multiply and one output per
// result and owns both handshakes. Depends on lir_pkg.
module lir_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  logic               out_ready,
	input  lir_pkg::lir_stat_t stat,
	output lir_pkg::lir_cmd_t  cmd
);
	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_MUL  = 3'b010,
		ST_OUT  = 3'b100
	} lir_state_t;

	lir_state_t state_q;
	lir_state_t state_d;
	logic       out_valid_q;
	logic       accept;
	logic       slot_free;

	assign in_ready = (state_q == ST_IDLE);
	assign accept = in_valid && in_ready;
	assign slot_free = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	always_comb begin
		cmd = '0;
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					priority if (!stat.have_prev) begin
						cmd.prime = 1'b1;
					end else if (!stat.pend_zero) begin
						cmd.skip = 1'b1;
					end else begin
						cmd.start = 1'b1;
						state_d = ST_MUL;
					end
				end
			end
			ST_MUL: begin
				cmd.step = 1'b1;
				state_d = ST_OUT;
			end
			ST_OUT: begin
				if (slot_free) begin
					cmd.emit = 1'b1;
					if (stat.last_out) begin
						cmd.retire = 1'b1;
						state_d = ST_IDLE;
					end else begin
						state_d = ST_MUL;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

`ifndef SYNTHESIS
	a_mul_to_out: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MUL) |=> (state_q == ST_OUT))
		else $error("multiply step not followed by output step");
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_OUT && out_valid_q && !out_ready) |=> (state_q == ST_OUT))
		else $error("output step left while the receiver stalls");
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit && stat.last_out) |=> (state_q == ST_IDLE && out_valid_q))
		else $error("last result not followed by idle with result pending");
`endif

endmodule

// ===== rtl/linear_interp_resampler.sv =====
// Top level of the linear interpolation resampler.
// Depends on lir_pkg, lir_if, lir_ctrl and lir_datapath.
//
// Usage: smp_in carries one signed source sample per transaction, smp_out
// one interpolated sample per transaction with last marking the final
// result caused by that source sample, and cfg writes the 4.16 phase step.
// The first sample after reset only primes the store. A sample that arrives
// while an integer advance is pending is stored and gives no result; such a
// transaction and a priming one leave the sequencer in its idle state.
// Otherwise each result passes a multiply step and then an output step
// that loads the output register; smp_in ready stays low until the last
// result's output step. The output register lets the next sample be
// accepted while the last result still waits. When the receiver stalls,
// the sequencer holds its result step and no state advances. Reset marks
// the sample store empty, clears phase and pending advance and sets the
// step to 1.0. Configuration is taken at any cycle and must only be written
// while the block is idle.
module linear_interp_resampler #(
	parameter int SAMPLE_BITS = 16,
	parameter int FRAC_BITS = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	lir_in_if.sink    smp_in,
	lir_out_if.source smp_out,
	lir_cfg_if.sink   cfg
);
	lir_pkg::lir_cmd_t  cmd;
	lir_pkg::lir_stat_t stat;

	assign cfg.ready = 1'b1;

	lir_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (smp_in.valid),
		.in_ready  (smp_in.ready),
		.out_valid (smp_out.valid),
		.out_ready (smp_out.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	lir_datapath #(
		.SAMPLE_BITS (SAMPLE_BITS),
		.FRAC_BITS   (FRAC_BITS)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.sample_in  (smp_in.sample_in),
		.step_we    (cfg.valid),
		.step_data  (cfg.phase_step),
		.sample_out (smp_out.sample_out),
		.last       (smp_out.last)
	);

endmodule

// ===== verif/linear_interp_resampler_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for linear_interp_resampler: a table of directed samples and step
// writes, then random phases, checked against typed values or an interpolation predictor.
// Depends on lir_pkg, the channel interfaces in lir_if and the resampler RTL.
module linear_interp_resampler_tb;

	localparam int SAMPLE_BITS = 16;
	localparam int IDLE_MAX = 16;
	localparam int SETTLE_CYCLES = 8;
	localparam int END_CYCLES = 40;
	localparam int HOLD_CYCLES = 400;
	localparam int HOLD_AT = 800;
	localparam int STALL_LIMIT = 3000;
	localparam int NUM_PHASES = 11;
	localparam int PHASE_ITEMS = 40;
	localparam int NUM_ROWS = 29;

	typedef enum logic [1:0] {ROW_SAMPLE, ROW_CFG} row_kind_t;
	typedef enum logic [1:0] {EXP_MODEL, EXP_NONE, EXP_ONE} exp_kind_t;

	typedef struct packed {
		row_kind_t     kind;
		logic [19:0]   value;
		exp_kind_t     exp;
		logic [15:0]   exp_sample;
	} row_t;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] value;
		logic                          last;
	} out_beat_t;

	// Step 1.0 after reset: each sample returns the previous one, frac stays zero.
	row_t dir_rows [NUM_ROWS] = '{
		'{ROW_SAMPLE, 20'h08000, EXP_NONE, 16'h0000},
		'{ROW_SAMPLE, 20'h07FFF, EXP_ONE, 16'h8000},
		'{ROW_SAMPLE, 20'h08000, EXP_ONE, 16'h7FFF},
		'{ROW_SAMPLE, 20'h00000, EXP_ONE, 16'h8000},
		'{ROW_SAMPLE, 20'h0FFFF, EXP_ONE, 16'h0000},
		'{ROW_SAMPLE, 20'h00001, EXP_ONE, 16'hFFFF},
		'{ROW_CFG, 20'h08000, EXP_MODEL, 16'h0000},
		'{ROW_SAMPLE, 20'h07FFF, EXP_MODEL, 16'h0000},
		'{ROW_SAMPLE, 20'h08000, EXP_MODEL, 16'h0000},
		'{ROW_SAMPLE, 20'h05555, EXP_MODEL, 16'h0000},
		'{ROW_SAMPLE, 20'h0AAAA, EXP_MODEL, 16'h0000},
		'{ROW_CFG, 20'h20000, EXP_MODEL, 16'h0000},
		'{ROW_SAMPLE, 20'h01234, EXP_MODEL, 16'h0000},
		'{ROW_SAMPLE, 20'h07FFF, EXP_MODEL, 16'h0000},
		'{ROW_SAMPLE, 20'h08000, EXP_MODEL, 16'h0000},
		'{ROW_SAMPLE, 20'h00F0F, EXP_MODEL, 16'h0000},
		'{ROW_CFG, 20'hFFFFF, EXP_MODEL, 16'h0000},
		'{ROW_SAMPLE, 20'h07FFF, EXP_MODEL, 16'h0000},
		'{ROW_SAMPLE, 20'h08000, EXP_MODEL, 16'h0000},
		'{ROW_SAMPLE, 20'h00064, EXP_MODEL, 16'h0000},
		'{ROW_CFG, 20'h00000, EXP_MODEL, 16'h0000},
		'{ROW_SAMPLE, 20'h07FFF, EXP_MODEL, 16'h0000},
		'{ROW_SAMPLE, 20'h08000, EXP_MODEL, 16'h0000},
		'{ROW_CFG, 20'h003FF, EXP_MODEL, 16'h0000},
		'{ROW_SAMPLE, 20'h04000, EXP_MODEL, 16'h0000},
		'{ROW_CFG, 20'h00400, EXP_MODEL, 16'h0000},
		'{ROW_SAMPLE, 20'h0B1E0, EXP_MODEL, 16'h0000},
		'{ROW_CFG, 20'h10000, EXP_MODEL, 16'h0000},
		'{ROW_SAMPLE, 20'h00000, EXP_MODEL, 16'h0000}
	};

	logic clk;
	logic arst_n;

	lir_in_if #(.SAMPLE_BITS(SAMPLE_BITS)) smp_in ();
	lir_out_if #(.SAMPLE_BITS(SAMPLE_BITS)) smp_out ();
	lir_cfg_if cfg ();

	linear_interp_resampler #(
		.SAMPLE_BITS(SAMPLE_BITS),
		.FRAC_BITS(16)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.smp_in(smp_in),
		.smp_out(smp_out),
		.cfg(cfg)
	);

	logic [lir_pkg::STEP_BITS-1:0] step_q = lir_pkg::STEP_RESET;
	logic signed [SAMPLE_BITS-1:0] prev_q = '0;
	logic                          primed_q = 1'b0;
	logic [15:0]                   frac_q = '0;
	logic [lir_pkg::PEND_BITS-1:0] pend_q = '0;

	out_beat_t expected_out [$];
	int errors = 0;
	int samples_sent = 0;
	int results_checked = 0;
	int steps_written = 0;
	bit send_fast = 1'b0;
	bit recv_fast = 1'b0;
	bit hold_done = 1'b0;

	initial begin : clock_gen
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	task automatic report_mismatch(input string msg);
		$display("%0t mismatch: %s", $realtime, msg);
		errors++;
	endtask

	function automatic logic signed [SAMPLE_BITS-1:0] lerp_sample(
		input logic signed [SAMPLE_BITS-1:0] a,
		input logic signed [SAMPLE_BITS-1:0] b,
		input logic [15:0] frac
	);
		longint num;
		num = longint'(a) * 65536 + longint'(frac) * (longint'(b) - longint'(a));
		return SAMPLE_BITS'(num / 65536);
	endfunction

	// Works out the results of one accepted sample and moves the predicted state on.
	task automatic advance_resampler(input logic signed [SAMPLE_BITS-1:0] cur, input bit keep);
		int n;
		logic [20:0] sum;
		out_beat_t beat;
		out_beat_t batch [$];
		n = 0;
		if (!primed_q) begin
			prev_q = cur;
			primed_q = 1'b1;
			return;
		end
		while (pend_q == 0 && n < lir_pkg::MAX_OUTS) begin
			beat.value = lerp_sample(prev_q, cur, frac_q);
			beat.last = 1'b0;
			sum = {5'b0, frac_q} + {1'b0, step_q};
			frac_q = sum[15:0];
			pend_q = (sum[20:16] > lir_pkg::PEND_MAX) ? lir_pkg::PEND_MAX : sum[20:16];
			batch.push_back(beat);
			n++;
		end
		if (n > 0)
			batch[n-1].last = 1'b1;
		prev_q = cur;
		if (pend_q > 0)
			pend_q--;
		if (keep)
			foreach (batch[i])
				expected_out.push_back(batch[i]);
	endtask

	task automatic send_sample(
		input logic signed [SAMPLE_BITS-1:0] s,
		input exp_kind_t ek,
		input logic signed [SAMPLE_BITS-1:0] typed
	);
		int gap;
		out_beat_t beat;
		gap = send_fast ? 0 : $urandom_range(0, IDLE_MAX);
		if (gap > 0) begin
			smp_in.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		smp_in.valid <= 1'b1;
		smp_in.sample_in <= s;
		do @(posedge clk); while (!smp_in.ready);
		samples_sent++;
		advance_resampler(s, ek == EXP_MODEL);
		if (ek == EXP_ONE) begin
			beat.value = typed;
			beat.last = 1'b1;
			expected_out.push_back(beat);
		end
	endtask

	// The block must be idle for a step write: drain all results, then let a skip finish.
	task automatic write_step(input logic [lir_pkg::STEP_BITS-1:0] value);
		smp_in.valid <= 1'b0;
		while (expected_out.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg.valid <= 1'b1;
		cfg.phase_step <= value;
		do @(posedge clk); while (!cfg.ready);
		cfg.valid <= 1'b0;
		step_q = value;
		steps_written++;
	endtask

	task automatic check_result(input logic signed [SAMPLE_BITS-1:0] value, input logic last);
		out_beat_t want;
		results_checked++;
		if (expected_out.size() == 0) begin
			report_mismatch($sformatf("result %0d with nothing expected", value));
			return;
		end
		want = expected_out.pop_front();
		if (value !== want.value)
			report_mismatch($sformatf("sample_out %0d, expected %0d", value, want.value));
		if (last !== want.last)
			report_mismatch($sformatf("last %b, expected %b", last, want.last));
	endtask

	initial begin : result_sink
		int gap;
		smp_out.ready <= 1'b0;
		@(posedge clk);
		while (arst_n !== 1'b1)
			@(posedge clk);
		forever begin
			if (results_checked % 64 == 0)
				recv_fast = ($urandom_range(0, 3) == 0);
			gap = recv_fast ? 0 : $urandom_range(0, IDLE_MAX);
			if (gap > 0) begin
				smp_out.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			smp_out.ready <= 1'b1;
			do @(posedge clk); while (!smp_out.valid);
			check_result(smp_out.sample_out, smp_out.last);
			if (!hold_done && results_checked == HOLD_AT) begin
				// Long receiver stall: the block fills and must back-pressure its input.
				hold_done = 1'b1;
				smp_out.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		forever begin
			@(posedge clk);
			if ((smp_in.valid && smp_in.ready) || (smp_out.valid && smp_out.ready)
					|| (cfg.valid && cfg.ready))
				quiet = 0;
			else
				quiet++;
			if (quiet == STALL_LIMIT) begin
				$display("timeout after %0d cycles without a transaction", STALL_LIMIT);
				$display("linear_interp_resampler_tb: errors");
				$finish;
			end
		end
	end

	initial begin : stimulus
		logic [lir_pkg::STEP_BITS-1:0] step;
		logic signed [SAMPLE_BITS-1:0] s;
		arst_n <= 1'b0;
		smp_in.valid <= 1'b0;
		smp_in.sample_in <= '0;
		cfg.valid <= 1'b0;
		cfg.phase_step <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		foreach (dir_rows[i]) begin
			send_fast = ($urandom_range(0, 2) == 0);
			if (dir_rows[i].kind == ROW_CFG)
				write_step(dir_rows[i].value);
			else
				send_sample(dir_rows[i].value[15:0], dir_rows[i].exp, dir_rows[i].exp_sample);
		end

		for (int p = 0; p < NUM_PHASES; p++) begin
			case (p)
				2: step = 20'd1024;
				5: step = 20'hFFFFF;
				7: step = 20'd0;
				9: step = 20'd1023;
				default: begin
					if ($urandom_range(0, 1) == 0)
						step = lir_pkg::STEP_BITS'($urandom_range(1024, 20'h1FFFF));
					else
						step = lir_pkg::STEP_BITS'($urandom_range(1024, 20'hFFFFF));
				end
			endcase
			write_step(step);
			send_fast = ($urandom_range(0, 3) == 0);
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				case ($urandom_range(0, 7))
					0: s = 16'sh7FFF;
					1: s = 16'sh8000;
					default: s = SAMPLE_BITS'($urandom());
				endcase
				send_sample(s, EXP_MODEL, '0);
			end
		end

		smp_in.valid <= 1'b0;
		while (expected_out.size() != 0)
			@(posedge clk);
		repeat (END_CYCLES) @(posedge clk);

		$display("summary: %0d samples sent, %0d results checked, %0d step writes",
			samples_sent, results_checked, steps_written);
		$display("summary: steps from 0 to full scale, output cap, skipped samples, %s",
			hold_done ? "long output stall" : "no long output stall");
		if (errors == 0)
			$display("linear_interp_resampler_tb: clean");
		else
			$display("linear_interp_resampler_tb: errors");
		$finish;
	end

endmodule
